// File: hdl/spbc_pkg.sv
// Shared types and constants of the SNTP poll scheduler with backoff and clock readout.
`default_nettype none

package spbc_pkg;

    localparam logic [31:0] NTP_UNIX_DELTA = 32'd2208988800;
    localparam logic [15:0] DELAY_CAP      = 16'd30000;

    localparam logic signed [17:0] OFFSET_RESET  = 18'sd0;
    localparam logic [31:0]        REFRESH_RESET = 32'd60000;
    localparam logic [15:0]        TIMEOUT_RESET = 16'd1000;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_TIME_OFFSET      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REFRESH_INTERVAL = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REQUEST_TIMEOUT  = 2'd2;

    localparam logic OP_POLL   = 1'b0;
    localparam logic OP_RESYNC = 1'b1;

    // Reciprocals for exact division by constants over the value ranges used.
    // x / 1000 for 32-bit x: (x * RECIP_1000) >> 41.
    localparam logic [31:0] RECIP_1000 = 32'd2199023256;
    // (x >> 7) / 675 for 32-bit x gives x / 86400: (x25 * RECIP_675) >> 35.
    localparam logic [25:0] RECIP_675  = 26'd50903317;
    // x / 7 for 17-bit x: (x * RECIP_7) >> 20.
    localparam logic [17:0] RECIP_7    = 18'd149797;
    // (x >> 4) / 225 gives x / 3600 for x below 86400: (x13 * RECIP_225) >> 21.
    localparam logic [13:0] RECIP_225  = 14'd9321;
    // (x >> 2) / 15 gives x / 60 for x below 3600: (x10 * RECIP_15) >> 14.
    localparam logic [10:0] RECIP_15   = 11'd1093;

    typedef struct packed {
        logic        send_request;
        logic        updated;
        logic [31:0] now_ms;
        logic [31:0] last_sync_ms;
        logic [31:0] synced_epoch;
    } clk_in_t;

    typedef struct packed {
        logic        send_request;
        logic        updated;
        logic [31:0] epoch_time;
        logic [2:0]  day_of_week;
        logic [4:0]  hour_of_day;
        logic [5:0]  minute_of_hour;
        logic [5:0]  second_of_minute;
        logic [9:0]  millisecond;
    } clk_out_t;

endpackage

`default_nettype wire

// File: hdl/spbc_clock.sv
// Pipelined clock readout: epoch, weekday, hours, minutes, seconds and milliseconds.
`default_nettype none

module spbc_clock (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic signed [17:0]    time_offset_s,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire spbc_pkg::clk_in_t     in_item,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output spbc_pkg::clk_out_t         out_item
);
    import spbc_pkg::*;

    localparam int NSTG = 10;

    typedef struct packed {
        logic        send_request;
        logic        updated;
        logic [31:0] now_ms;
        logic [31:0] last_sync_ms;
        logic [31:0] synced_epoch;
        logic [31:0] since;
        logic [31:0] base;
        logic [22:0] q_ms;
        logic [9:0]  ms;
        logic [31:0] ep;
        logic [15:0] q_day;
        logic [16:0] rem_day;
        logic [16:0] dp;
        logic [13:0] dq;
        logic [2:0]  dow;
        logic [4:0]  hour;
        logic [11:0] rem_hour;
        logic [5:0]  minute;
        logic [5:0]  sec;
    } pipe_t;

    pipe_t st_reg [NSTG];
    pipe_t st_next [NSTG];
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] adv;

    logic [63:0] p_ms;
    logic [50:0] p_day;
    logic [34:0] p_dow;
    logic [26:0] p_hour;
    logic [20:0] p_min;
    logic [31:0] offset_ext;

    assign offset_ext = {{14{time_offset_s[17]}}, time_offset_s};

    assign p_ms   = 64'(st_reg[1].since) * 64'(RECIP_1000);
    assign p_day  = 51'(st_reg[3].ep[31:7]) * 51'(RECIP_675);
    assign p_dow  = 35'(st_reg[4].q_day + 16'd4) * 35'(RECIP_7);
    assign p_hour = 27'(st_reg[5].rem_day[16:4]) * 27'(RECIP_225);
    assign p_min  = 21'(st_reg[7].rem_hour[11:2]) * 21'(RECIP_15);

    always_comb begin
        st_next[0] = '0;
        st_next[0].send_request = in_item.send_request;
        st_next[0].updated      = in_item.updated;
        st_next[0].now_ms       = in_item.now_ms;
        st_next[0].last_sync_ms = in_item.last_sync_ms;
        st_next[0].synced_epoch = in_item.synced_epoch;

        st_next[1] = st_reg[0];
        st_next[1].since = st_reg[0].now_ms - st_reg[0].last_sync_ms;
        st_next[1].base  = offset_ext + st_reg[0].synced_epoch;

        st_next[2] = st_reg[1];
        st_next[2].q_ms = p_ms[63:41];

        st_next[3] = st_reg[2];
        st_next[3].ms = 10'(st_reg[2].since - {9'b0, st_reg[2].q_ms} * 32'd1000);
        st_next[3].ep = st_reg[2].base + {9'b0, st_reg[2].q_ms};

        st_next[4] = st_reg[3];
        st_next[4].q_day = p_day[50:35];

        st_next[5] = st_reg[4];
        st_next[5].rem_day = 17'(st_reg[4].ep - {16'b0, st_reg[4].q_day} * 32'd86400);
        st_next[5].dp      = {1'b0, st_reg[4].q_day} + 17'd4;
        st_next[5].dq      = p_dow[33:20];

        st_next[6] = st_reg[5];
        st_next[6].dow  = 3'(st_reg[5].dp - {3'b0, st_reg[5].dq} * 17'd7);
        st_next[6].hour = p_hour[25:21];

        st_next[7] = st_reg[6];
        st_next[7].rem_hour = 12'(st_reg[6].rem_day - {12'b0, st_reg[6].hour} * 17'd3600);

        st_next[8] = st_reg[7];
        st_next[8].minute = p_min[19:14];

        st_next[9] = st_reg[8];
        st_next[9].sec = 6'(st_reg[8].rem_hour - {6'b0, st_reg[8].minute} * 12'd60);
    end

    always_comb begin
        adv[NSTG-1] = !v_reg[NSTG-1] || out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign in_ready = adv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (adv[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (adv[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (adv[k]) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign out_valid                 = v_reg[NSTG-1];
    assign out_item.send_request     = st_reg[NSTG-1].send_request;
    assign out_item.updated          = st_reg[NSTG-1].updated;
    assign out_item.epoch_time       = st_reg[NSTG-1].ep;
    assign out_item.day_of_week      = st_reg[NSTG-1].dow;
    assign out_item.hour_of_day      = st_reg[NSTG-1].hour;
    assign out_item.minute_of_hour   = st_reg[NSTG-1].minute;
    assign out_item.second_of_minute = st_reg[NSTG-1].sec;
    assign out_item.millisecond      = st_reg[NSTG-1].ms;

endmodule

`default_nettype wire

// File: hdl/sntp_poll_backoff_clock_core.sv
// Top level: request register, poll scheduler with backoff, and clock readout pipeline.
// The scheduler state updates as each registered request enters the readout pipeline.
// Throughput is one request per cycle while m_ready does not stall the pipeline.
// The clock readout is a 10-stage pipeline of constant-reciprocal multiplies.
// Synchronous active-low reset clears the scheduler state, sets the configuration
// registers to their defaults and empties the pipeline.
`default_nettype none

module sntp_poll_backoff_clock_core (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [spbc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [spbc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_operation,
    input  wire logic [31:0]                        s_now_ms,
    input  wire logic                               s_reply_valid,
    input  wire logic [31:0]                        s_reply_seconds,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_send_request,
    output logic                                    m_updated,
    output logic [31:0]                             m_epoch_time,
    output logic [2:0]                              m_day_of_week,
    output logic [4:0]                              m_hour_of_day,
    output logic [5:0]                              m_minute_of_hour,
    output logic [5:0]                              m_second_of_minute,
    output logic [9:0]                              m_millisecond
);
    import spbc_pkg::*;

    logic signed [17:0] time_offset_reg;
    logic [31:0]        refresh_reg;
    logic [15:0]        timeout_reg;

    logic        in_v_reg;
    logic        op_reg;
    logic [31:0] now_reg;
    logic        rvalid_reg;
    logic [31:0] rsec_reg;

    logic [31:0] last_sync_reg, last_sync_next;
    logic [31:0] sent_reg, sent_next;
    logic [14:0] delay_reg, delay_next;
    logic [31:0] epoch_reg, epoch_next;

    logic        send, upd, hold, fire;
    logic [31:0] limit;
    logic [15:0] doubled;
    logic        clk_ready, clk_take;
    clk_in_t     clk_in;
    clk_out_t    clk_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_offset_reg <= OFFSET_RESET;
            refresh_reg     <= REFRESH_RESET;
            timeout_reg     <= TIMEOUT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_TIME_OFFSET:      time_offset_reg <= signed'(cfg_data[17:0]);
                REG_REFRESH_INTERVAL: refresh_reg     <= cfg_data;
                REG_REQUEST_TIMEOUT:  timeout_reg     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign s_ready  = !in_v_reg || clk_ready;
    assign clk_take = in_v_reg && clk_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (s_ready) begin
            in_v_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            op_reg     <= s_operation;
            now_reg    <= s_now_ms;
            rvalid_reg <= s_reply_valid;
            rsec_reg   <= s_reply_seconds;
        end
    end

    assign hold    = (last_sync_reg != 32'd0) && (now_reg < last_sync_reg + refresh_reg);
    assign limit   = sent_reg + {17'b0, delay_reg} + {16'b0, timeout_reg};
    assign fire    = (sent_reg == 32'd0) || (now_reg > limit);
    assign doubled = {delay_reg, 1'b0};

    always_comb begin
        last_sync_next = last_sync_reg;
        sent_next      = sent_reg;
        delay_next     = delay_reg;
        epoch_next     = epoch_reg;
        send           = 1'b0;
        upd            = 1'b0;
        if (op_reg == OP_RESYNC) begin
            last_sync_next = 32'd0;
            sent_next      = 32'd0;
            delay_next     = 15'd1;
        end else if (!hold) begin
            if (fire) begin
                if (sent_reg != 32'd0) begin
                    delay_next = (doubled > DELAY_CAP) ? 15'(DELAY_CAP) : doubled[14:0];
                end
                send      = 1'b1;
                sent_next = now_reg;
            end
            if (rvalid_reg) begin
                epoch_next     = rsec_reg - NTP_UNIX_DELTA;
                sent_next      = 32'd0;
                delay_next     = 15'd1;
                last_sync_next = now_reg;
                upd            = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_sync_reg <= 32'd0;
            sent_reg      <= 32'd0;
            delay_reg     <= 15'd1;
            epoch_reg     <= 32'd0;
        end else if (clk_take) begin
            last_sync_reg <= last_sync_next;
            sent_reg      <= sent_next;
            delay_reg     <= delay_next;
            epoch_reg     <= epoch_next;
        end
    end

    assign clk_in.send_request = send;
    assign clk_in.updated      = upd;
    assign clk_in.now_ms       = now_reg;
    assign clk_in.last_sync_ms = last_sync_next;
    assign clk_in.synced_epoch = epoch_next;

    spbc_clock u_clock (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .time_offset_s (time_offset_reg),
        .in_valid      (in_v_reg),
        .in_ready      (clk_ready),
        .in_item       (clk_in),
        .out_valid     (m_valid),
        .out_ready     (m_ready),
        .out_item      (clk_out)
    );

    assign m_send_request     = clk_out.send_request;
    assign m_updated          = clk_out.updated;
    assign m_epoch_time       = clk_out.epoch_time;
    assign m_day_of_week      = clk_out.day_of_week;
    assign m_hour_of_day      = clk_out.hour_of_day;
    assign m_minute_of_hour   = clk_out.minute_of_hour;
    assign m_second_of_minute = clk_out.second_of_minute;
    assign m_millisecond      = clk_out.millisecond;

endmodule

`default_nettype wire
